@@ rtl/core/brb_pkg.sv @@
package brb_pkg;

   localparam int BYTE_W       = 8;
   localparam int OP_W         = 3;
   localparam int RING_SIZE_W  = 9;
   localparam int DEPTH_DEFAULT = 256;
   localparam int SIZE_LIMIT   = 256;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE     = 3'd0,
      OP_OVERWRITE = 3'd1,
      OP_READ      = 3'd2,
      OP_PEEK      = 3'd3,
      OP_SKIP      = 3'd4,
      OP_STEP      = 3'd5,
      OP_CLEAR     = 3'd6
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

endpackage

@@ rtl/core/brb_mem.sv @@
module brb_mem #(
   parameter int ENTRIES = brb_pkg::DEPTH_DEFAULT,
   parameter int ADDR_W  = $clog2(ENTRIES)
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [ADDR_W-1:0]          waddr,
   input  logic [brb_pkg::BYTE_W-1:0] wdata,
   input  logic                       re,
   input  logic [ADDR_W-1:0]          raddr,
   output logic [brb_pkg::BYTE_W-1:0] rdata
);

   logic [brb_pkg::BYTE_W-1:0] storage_ff [ENTRIES];
   logic [brb_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         storage_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rd_data_ff <= storage_ff[raddr];
      end
   end

   assign rdata = rd_data_ff;

endmodule

@@ rtl/core/brb_ctrl.sv @@
module brb_ctrl #(
   parameter int DEPTH = brb_pkg::DEPTH_DEFAULT,
   parameter int CAP   = (DEPTH < brb_pkg::SIZE_LIMIT) ? DEPTH : brb_pkg::SIZE_LIMIT,
   parameter int PTR_W = $clog2(CAP)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [brb_pkg::RING_SIZE_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [brb_pkg::OP_W-1:0]        req_opcode,
   input  logic [brb_pkg::BYTE_W-1:0]      req_data_in,
   input  logic [brb_pkg::BYTE_W-1:0]      req_amount,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_data_out,
   output logic                            rsp_ok,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_done_count,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_filled,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_free_space,
   output logic                            mem_we,
   output logic [PTR_W-1:0]                mem_waddr,
   output logic [brb_pkg::BYTE_W-1:0]      mem_wdata,
   output logic                            mem_re,
   output logic [PTR_W-1:0]                mem_raddr,
   input  logic [brb_pkg::BYTE_W-1:0]      mem_rdata
);

   localparam int SW = brb_pkg::RING_SIZE_W;
   localparam logic [SW-1:0] CAP_SIZE = SW'(CAP);
   localparam logic [SW-1:0] MIN_SIZE = SW'(2);
   localparam logic [SW-1:0] ONE      = SW'(1);

   function automatic logic [SW-1:0] wrap_add(logic [SW-1:0] idx, logic [SW-1:0] n,
                                              logic [SW-1:0] size);
      logic [SW:0] r;
      r = {1'b0, idx} + {1'b0, n};
      if (r >= {1'b0, size}) begin
         r = r - {1'b0, size};
      end
      return r[SW-1:0];
   endfunction

   brb_pkg::state_type state_ff, state_in;

   logic [SW-1:0]    ring_size_ff, ring_size_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;

   logic                       rsp_sel_ff, rsp_sel_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [brb_pkg::BYTE_W-1:0] rsp_done_ff, rsp_done_in;
   logic [brb_pkg::BYTE_W-1:0] rsp_filled_ff, rsp_filled_in;
   logic [brb_pkg::BYTE_W-1:0] rsp_free_ff, rsp_free_in;

   logic              accept;
   logic [SW-1:0]     rp, wp, amt, filled, free, n_cnt, filled_new, free_new, rp_next, wp_next;
   logic [SW-1:0]     size_clamped;

   assign accept = req_valid && req_ready;
   assign rp     = {{(SW-PTR_W){1'b0}}, rd_ptr_ff};
   assign wp     = {{(SW-PTR_W){1'b0}}, wr_ptr_ff};
   assign amt    = {{(SW-brb_pkg::BYTE_W){1'b0}}, req_amount};
   assign filled = (wp >= rp) ? (wp - rp) : (ring_size_ff - (rp - wp));
   assign free   = ring_size_ff - ONE - filled;

   always_comb begin
      if (csr_wdata < MIN_SIZE) begin
         size_clamped = MIN_SIZE;
      end else if (csr_wdata > CAP_SIZE) begin
         size_clamped = CAP_SIZE;
      end else begin
         size_clamped = csr_wdata;
      end
   end

   always_comb begin
      rp_next     = rp;
      wp_next     = wp;
      filled_new  = filled;
      n_cnt       = '0;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = wr_ptr_ff;
      mem_wdata   = req_data_in;
      mem_raddr   = rd_ptr_ff;
      rsp_sel_in  = 1'b0;
      rsp_ok_in   = 1'b0;
      unique case (req_opcode)
         brb_pkg::OP_WRITE: begin
            if (free != '0) begin
               mem_we     = accept;
               wp_next    = wrap_add(wp, ONE, ring_size_ff);
               filled_new = filled + ONE;
               n_cnt      = ONE;
               rsp_ok_in  = 1'b1;
            end
         end
         brb_pkg::OP_OVERWRITE: begin
            if (free == '0) begin
               rp_next = wrap_add(rp, ONE, ring_size_ff);
            end else begin
               filled_new = filled + ONE;
            end
            mem_we    = accept;
            wp_next   = wrap_add(wp, ONE, ring_size_ff);
            n_cnt     = ONE;
            rsp_ok_in = 1'b1;
         end
         brb_pkg::OP_READ: begin
            if (filled != '0) begin
               mem_re     = accept;
               rp_next    = wrap_add(rp, ONE, ring_size_ff);
               filled_new = filled - ONE;
               n_cnt      = ONE;
               rsp_ok_in  = 1'b1;
               rsp_sel_in = 1'b1;
            end
         end
         brb_pkg::OP_PEEK: begin
            mem_raddr = PTR_W'(wrap_add(rp, amt, ring_size_ff));
            if (amt < filled) begin
               mem_re     = accept;
               n_cnt      = ONE;
               rsp_ok_in  = 1'b1;
               rsp_sel_in = 1'b1;
            end
         end
         brb_pkg::OP_SKIP: begin
            n_cnt      = (amt < filled) ? amt : filled;
            rp_next    = wrap_add(rp, n_cnt, ring_size_ff);
            filled_new = filled - n_cnt;
            rsp_ok_in  = (n_cnt != '0);
         end
         brb_pkg::OP_STEP: begin
            n_cnt      = (amt < free) ? amt : free;
            wp_next    = wrap_add(wp, n_cnt, ring_size_ff);
            filled_new = filled + n_cnt;
            rsp_ok_in  = (n_cnt != '0);
         end
         brb_pkg::OP_CLEAR: begin
            rp_next    = '0;
            wp_next    = '0;
            filled_new = '0;
            rsp_ok_in  = 1'b1;
         end
         default: begin
         end
      endcase
      free_new      = ring_size_ff - ONE - filled_new;
      rsp_done_in   = n_cnt[brb_pkg::BYTE_W-1:0];
      rsp_filled_in = filled_new[brb_pkg::BYTE_W-1:0];
      rsp_free_in   = free_new[brb_pkg::BYTE_W-1:0];
   end

   always_comb begin
      ring_size_in = ring_size_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      if (csr_we) begin
         ring_size_in = size_clamped;
         rd_ptr_in    = '0;
         wr_ptr_in    = '0;
      end else if (accept) begin
         rd_ptr_in = rp_next[PTR_W-1:0];
         wr_ptr_in = wp_next[PTR_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         brb_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = brb_pkg::ST_RESP;
            end
         end
         brb_pkg::ST_RESP: begin
            if (rsp_ready) begin
               state_in = brb_pkg::ST_IDLE;
            end
         end
         default: state_in = brb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         brb_pkg::ST_IDLE: req_ready = 1'b1;
         brb_pkg::ST_RESP: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brb_pkg::ST_IDLE;
         ring_size_ff <= CAP_SIZE;
         rd_ptr_ff    <= '0;
         wr_ptr_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         ring_size_ff <= ring_size_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_sel_ff    <= rsp_sel_in;
         rsp_ok_ff     <= rsp_ok_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_filled_ff <= rsp_filled_in;
         rsp_free_ff   <= rsp_free_in;
      end
   end

   assign rsp_data_out   = rsp_sel_ff ? mem_rdata : '0;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_done_count = rsp_done_ff;
   assign rsp_filled     = rsp_filled_ff;
   assign rsp_free_space = rsp_free_ff;

endmodule

@@ rtl/core/byte_ring_buffer_top.sv @@
// Byte ring buffer holding up to ring_size - 1 bytes in a synchronous memory
// of min(DEPTH, 256) entries. Each request transaction carries an opcode
// (write, overwrite, read, peek, skip, step write, clear) and yields exactly
// one response transaction with the byte seen, a success flag, the count done
// and the filled and free space after the operation. A request is accepted in
// the idle state, where the pointers are updated and the memory port accessed;
// the response is then held in the response state, its data from the memory's
// registered read output; the next request is accepted once the response is
// taken. Writing csr_wdata sets ring_size (clamped to 2..min(DEPTH, 256)) and
// clears both pointers; write it only while no transaction is in flight.
// Storage is not cleared at reset: reading a slot never written returns an
// undefined byte.
module byte_ring_buffer_top #(
   parameter int DEPTH = brb_pkg::DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [brb_pkg::RING_SIZE_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [brb_pkg::OP_W-1:0]        req_opcode,
   input  logic [brb_pkg::BYTE_W-1:0]      req_data_in,
   input  logic [brb_pkg::BYTE_W-1:0]      req_amount,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_data_out,
   output logic                            rsp_ok,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_done_count,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_filled,
   output logic [brb_pkg::BYTE_W-1:0]      rsp_free_space
);

   localparam int CAP   = (DEPTH < brb_pkg::SIZE_LIMIT) ? DEPTH : brb_pkg::SIZE_LIMIT;
   localparam int PTR_W = $clog2(CAP);

   logic                       mem_we;
   logic [PTR_W-1:0]           mem_waddr;
   logic [brb_pkg::BYTE_W-1:0] mem_wdata;
   logic                       mem_re;
   logic [PTR_W-1:0]           mem_raddr;
   logic [brb_pkg::BYTE_W-1:0] mem_rdata;

   brb_ctrl #(
      .DEPTH (DEPTH),
      .CAP   (CAP),
      .PTR_W (PTR_W)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_data_in    (req_data_in),
      .req_amount     (req_amount),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_out   (rsp_data_out),
      .rsp_ok         (rsp_ok),
      .rsp_done_count (rsp_done_count),
      .rsp_filled     (rsp_filled),
      .rsp_free_space (rsp_free_space),
      .mem_we         (mem_we),
      .mem_waddr      (mem_waddr),
      .mem_wdata      (mem_wdata),
      .mem_re         (mem_re),
      .mem_raddr      (mem_raddr),
      .mem_rdata      (mem_rdata)
   );

   brb_mem #(
      .ENTRIES (CAP),
      .ADDR_W  (PTR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

endmodule
